### hw/rtl/scan_order_coordinate_generator_core_assert.svh
// ----------------------------------------------------------------------------
// Scan-order coordinate generator: assertion macros
// Short concurrent assertion forms shared by the RTL of this block. They use
// the clk and rst_n names of the module that includes them.
// ----------------------------------------------------------------------------
`ifndef SCAN_ORDER_COORDINATE_GENERATOR_CORE_ASSERT_SVH
`define SCAN_ORDER_COORDINATE_GENERATOR_CORE_ASSERT_SVH

// The expression must never be true at a clock edge outside reset.
`define SOCG_ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("socg: forbidden condition seen");

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define SOCG_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("socg: implication violated");

`endif

### hw/rtl/socg_pkg.sv
// ----------------------------------------------------------------------------
// Scan-order coordinate generator: package
// Map geometry, mode and command codes, the spiral order table and the
// radial coordinate helper shared by the front end and the back end.
// ----------------------------------------------------------------------------
package socg_pkg;

    localparam int MAP_WIDTH     = 16;
    localparam int RADIAL_LENGTH = 16;
    localparam int SPOKE_COUNT   = 8;

    localparam int CELL_COUNT    = MAP_WIDTH * MAP_WIDTH;
    localparam int SPOKE_PERIOD  = SPOKE_COUNT * RADIAL_LENGTH;
    localparam int MAX_PERIOD    = (CELL_COUNT > SPOKE_PERIOD) ? CELL_COUNT : SPOKE_PERIOD;

    localparam int STEP_W  = $clog2(MAX_PERIOD);
    localparam int CELL_W  = $clog2(CELL_COUNT);
    localparam int COORD_W = $clog2(MAP_WIDTH);
    localparam int OUT_W   = 4;
    localparam int RAD_W   = (RADIAL_LENGTH > 1) ? $clog2(RADIAL_LENGTH) : 1;
    localparam int SPOKE_W = 3;
    localparam int SUM_W   = $clog2(MAP_WIDTH + RADIAL_LENGTH) + 2;
    localparam int MODE_W  = 3;
    localparam int SEEK_W  = 32;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    // Mode register codes; codes above MODE_RADIAL behave as radial.
    localparam logic [MODE_W-1:0] MODE_RASTER     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_BOUSTRO    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SPIRAL_IN  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SPIRAL_OUT = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RADIAL     = 3'd4;

    localparam logic CMD_ADVANCE = 1'b0;
    localparam logic CMD_SEEK    = 1'b1;

    // Register index taken from paddr bit 2.
    localparam logic REG_MODE_IDX = 1'b0;

    typedef enum logic [2:0] {
        SCAN_RASTER,
        SCAN_BOUSTRO,
        SCAN_SPIRAL_IN,
        SCAN_SPIRAL_OUT,
        SCAN_RADIAL
    } scan_kind_t;

    // One advance item handed from the front end to the back end.
    typedef struct packed {
        scan_kind_t          kind;
        logic [STEP_W-1:0]   step;
    } scan_op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef logic [CELL_COUNT-1:0][CELL_W-1:0] spiral_rom_t;

    localparam logic signed [1:0] DIR_COL [SPOKE_COUNT] =
        '{2'sd1, 2'sd1, 2'sd0, -2'sd1, -2'sd1, -2'sd1, 2'sd0, 2'sd1};
    localparam logic signed [1:0] DIR_ROW [SPOKE_COUNT] =
        '{2'sd0, -2'sd1, -2'sd1, -2'sd1, 2'sd0, 2'sd1, 2'sd1, 2'sd1};

    // Clockwise spiral from the top-left corner, moving inward.
    function automatic spiral_rom_t build_spiral();
        spiral_rom_t rom;
        int t;
        int b;
        int l;
        int r;
        int n;
        int i;
        rom = '0;
        t = 0;
        b = MAP_WIDTH - 1;
        l = 0;
        r = MAP_WIDTH - 1;
        n = 0;
        while (t <= b && l <= r) begin
            for (i = l; i <= r; i++) begin
                if (n < CELL_COUNT) begin
                    rom[n] = CELL_W'(t * MAP_WIDTH + i);
                    n++;
                end
            end
            t++;
            for (i = t; i <= b; i++) begin
                if (n < CELL_COUNT) begin
                    rom[n] = CELL_W'(i * MAP_WIDTH + r);
                    n++;
                end
            end
            r--;
            if (t <= b) begin
                for (i = r; i >= l; i--) begin
                    if (n < CELL_COUNT) begin
                        rom[n] = CELL_W'(b * MAP_WIDTH + i);
                        n++;
                    end
                end
                b--;
            end
            if (l <= r) begin
                for (i = b; i >= t; i--) begin
                    if (n < CELL_COUNT) begin
                        rom[n] = CELL_W'(i * MAP_WIDTH + l);
                        n++;
                    end
                end
                l++;
            end
        end
        return rom;
    endfunction

    localparam spiral_rom_t SPIRAL_ROM = build_spiral();

    // One axis of a radial point: centre plus signed radius, clamped to the map.
    function automatic logic [COORD_W-1:0] radial_axis(
        input logic signed [1:0] dir,
        input logic [RAD_W-1:0]  rad
    );
        logic signed [SUM_W-1:0] centre;
        logic signed [SUM_W-1:0] offs;
        logic signed [SUM_W-1:0] sum;
        centre = SUM_W'(MAP_WIDTH / 2);
        offs   = SUM_W'(rad);
        if (dir > 2'sd0) begin
            sum = centre + offs;
        end else if (dir < 2'sd0) begin
            sum = centre - offs;
        end else begin
            sum = centre;
        end
        if (sum < 0) begin
            return '0;
        end else if (sum > SUM_W'(MAP_WIDTH - 1)) begin
            return COORD_W'(MAP_WIDTH - 1);
        end
        return COORD_W'(sum);
    endfunction

endpackage

### hw/rtl/socg_front.sv
// ----------------------------------------------------------------------------
// Scan-order coordinate generator: front end
// Holds the mode register and the step counter, accepts items, applies seeks
// and passes each advance to the queue with the step it reads.
// ----------------------------------------------------------------------------
module socg_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr,
    input  logic [socg_pkg::MODE_W-1:0]   cfg_mode,
    output logic [socg_pkg::MODE_W-1:0]   mode,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          cmd,
    input  logic [socg_pkg::SEEK_W-1:0]   seek_step,
    input  socg_pkg::fifo_stat_t          q_stat,
    output logic                          q_push,
    output socg_pkg::scan_op_t            q_op
);

    logic [socg_pkg::MODE_W-1:0] mode_reg;
    logic [socg_pkg::MODE_W-1:0] mode_next;
    logic [socg_pkg::STEP_W-1:0] step_reg;
    logic [socg_pkg::STEP_W-1:0] step_next;
    logic [socg_pkg::STEP_W-1:0] last_step;
    logic [socg_pkg::STEP_W-1:0] seek_wrapped;
    socg_pkg::scan_kind_t        kind;
    logic                        accept;

    always_comb
    begin
        unique case (mode_reg)
            socg_pkg::MODE_RASTER:     kind = socg_pkg::SCAN_RASTER;
            socg_pkg::MODE_BOUSTRO:    kind = socg_pkg::SCAN_BOUSTRO;
            socg_pkg::MODE_SPIRAL_IN:  kind = socg_pkg::SCAN_SPIRAL_IN;
            socg_pkg::MODE_SPIRAL_OUT: kind = socg_pkg::SCAN_SPIRAL_OUT;
            default:                   kind = socg_pkg::SCAN_RADIAL;
        endcase
    end

    // Both periods are powers of two, so the seek reduction is a mask.
    always_comb
    begin
        if (kind == socg_pkg::SCAN_RADIAL) begin
            last_step    = socg_pkg::STEP_W'(socg_pkg::SPOKE_PERIOD - 1);
            seek_wrapped = socg_pkg::STEP_W'(seek_step % socg_pkg::SEEK_W'(socg_pkg::SPOKE_PERIOD));
        end else begin
            last_step    = socg_pkg::STEP_W'(socg_pkg::CELL_COUNT - 1);
            seek_wrapped = socg_pkg::STEP_W'(seek_step % socg_pkg::SEEK_W'(socg_pkg::CELL_COUNT));
        end
    end

    assign in_stall = q_stat.full;
    assign accept   = in_valid && !q_stat.full;
    assign q_push   = accept && (cmd == socg_pkg::CMD_ADVANCE);
    assign q_op     = '{kind: kind, step: step_reg};
    assign mode     = mode_reg;

    always_comb
    begin
        mode_next = mode_reg;
        step_next = step_reg;
        if (cfg_wr) begin
            mode_next = cfg_mode;
            step_next = '0;
        end else if (accept) begin
            if (cmd == socg_pkg::CMD_SEEK) begin
                step_next = seek_wrapped;
            end else if (step_reg == last_step) begin
                step_next = '0;
            end else begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= socg_pkg::MODE_RASTER;
            step_reg <= '0;
        end else begin
            mode_reg <= mode_next;
            step_reg <= step_next;
        end
    end

endmodule

### hw/rtl/socg_queue.sv
// ----------------------------------------------------------------------------
// Scan-order coordinate generator: operation queue
// Two-entry queue of advance operations between the front and back ends.
// ----------------------------------------------------------------------------
module socg_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  socg_pkg::scan_op_t   push_op,
    input  logic                 pop,
    output socg_pkg::scan_op_t   head_op,
    output socg_pkg::fifo_stat_t stat
);

    socg_pkg::scan_op_t entry_reg [2];
    logic               wr_ptr_reg;
    logic               wr_ptr_next;
    logic               rd_ptr_reg;
    logic               rd_ptr_next;
    logic [1:0]         count_reg;
    logic [1:0]         count_next;

    assign head_op    = entry_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### hw/rtl/socg_back.sv
// ----------------------------------------------------------------------------
// Scan-order coordinate generator: back end
// Turns a queued step into map coordinates and holds them in the output
// register until they are taken.
// ----------------------------------------------------------------------------
module socg_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  socg_pkg::scan_op_t           head_op,
    input  socg_pkg::fifo_stat_t         q_stat,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [socg_pkg::OUT_W-1:0]   x_coord,
    output logic [socg_pkg::OUT_W-1:0]   y_coord
);

    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [socg_pkg::COORD_W-1:0]   x_reg;
    logic [socg_pkg::COORD_W-1:0]   y_reg;
    logic [socg_pkg::COORD_W-1:0]   x_next;
    logic [socg_pkg::COORD_W-1:0]   y_next;
    logic [socg_pkg::CELL_W-1:0]    rom_index;
    logic [socg_pkg::CELL_W-1:0]    map_idx;
    logic [socg_pkg::SPOKE_W-1:0]   spoke;
    logic [socg_pkg::RAD_W-1:0]     rad;

    assign pop = !q_stat.empty && (!out_valid_reg || !out_stall);

    always_comb
    begin
        if (head_op.kind == socg_pkg::SCAN_SPIRAL_OUT) begin
            rom_index = socg_pkg::CELL_W'(socg_pkg::CELL_COUNT - 1) -
                        socg_pkg::CELL_W'(head_op.step);
        end else begin
            rom_index = socg_pkg::CELL_W'(head_op.step);
        end
        spoke = socg_pkg::SPOKE_W'(head_op.step / socg_pkg::STEP_W'(socg_pkg::RADIAL_LENGTH));
        rad   = socg_pkg::RAD_W'(head_op.step % socg_pkg::STEP_W'(socg_pkg::RADIAL_LENGTH));

        unique case (head_op.kind)
            socg_pkg::SCAN_SPIRAL_IN,
            socg_pkg::SCAN_SPIRAL_OUT: map_idx = socg_pkg::SPIRAL_ROM[rom_index];
            default:                   map_idx = socg_pkg::CELL_W'(head_op.step);
        endcase

        x_next = socg_pkg::COORD_W'(map_idx % socg_pkg::CELL_W'(socg_pkg::MAP_WIDTH));
        y_next = socg_pkg::COORD_W'(map_idx / socg_pkg::CELL_W'(socg_pkg::MAP_WIDTH));

        unique case (head_op.kind)
            socg_pkg::SCAN_BOUSTRO:
            begin
                // Odd rows run right to left.
                if (y_next[0]) begin
                    x_next = socg_pkg::COORD_W'(socg_pkg::MAP_WIDTH - 1) - x_next;
                end
            end
            socg_pkg::SCAN_RADIAL:
            begin
                x_next = socg_pkg::radial_axis(socg_pkg::DIR_COL[spoke], rad);
                y_next = socg_pkg::radial_axis(socg_pkg::DIR_ROW[spoke], rad);
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        if (pop) begin
            out_valid_next = 1'b1;
        end else if (out_stall) begin
            out_valid_next = out_valid_reg;
        end else begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop) begin
            x_reg <= x_next;
            y_reg <= y_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign x_coord   = socg_pkg::OUT_W'(x_reg);
    assign y_coord   = socg_pkg::OUT_W'(y_reg);

endmodule

### hw/rtl/scan_order_coordinate_generator_core.sv
// ----------------------------------------------------------------------------
// Scan-order coordinate generator
// Playhead over a 16 x 16 map giving raster, boustrophedon, spiral and
// radial-spoke scan orders, one coordinate per advance item.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while in_stall is low and, once
// primed, returns one coordinate per cycle while out_stall is low. An advance
// item accepted at a clock edge is written into the two-entry operation queue
// at that edge and moves into the output register when the back end pops it,
// which a stall on the output side can hold off; its coordinate is then valid
// on x_coord/y_coord until taken. Spiral table lookup, boustrophedon reversal
// and radial clamp all sit combinationally between those two registers.
// An advance item returns the cell at the current step and then moves the
// step on by one, wrapping at 256 (all map cells) or, in radial mode, at 128
// (eight spokes of sixteen radii). A seek item loads the step with its
// seek_step value reduced modulo that period and returns nothing. Mode codes
// 5 to 7 behave as radial. Writing the mode register at byte address 0 sets
// the step back to zero; it should be written only while no item is in
// flight. in_stall rises only when the two-entry queue is full, which happens
// solely when the output side stalls.
// ----------------------------------------------------------------------------
`include "scan_order_coordinate_generator_core_assert.svh"

module scan_order_coordinate_generator_core (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [socg_pkg::ADDR_W-1:0]   paddr,
    input  logic [socg_pkg::DATA_W-1:0]   pwdata,
    output logic [socg_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    // Input item channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          cmd,
    input  logic [socg_pkg::SEEK_W-1:0]   seek_step,
    // Result item channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [socg_pkg::OUT_W-1:0]    x_coord,
    output logic [socg_pkg::OUT_W-1:0]    y_coord
);

    logic                          cfg_wr;
    logic [socg_pkg::MODE_W-1:0]   mode;
    logic                          q_push;
    logic                          q_pop;
    socg_pkg::scan_op_t            q_op;
    socg_pkg::scan_op_t            head_op;
    socg_pkg::fifo_stat_t          q_stat;

    // The port never waits. Only the mode register is decoded; writes to
    // any other address are ignored and read back as zero.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == socg_pkg::REG_MODE_IDX);

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == socg_pkg::REG_MODE_IDX) begin
            prdata = socg_pkg::DATA_W'(mode);
        end
    end

    // The front end keeps the step state, so seeks and advances are resolved
    // in the order they arrive even while the back end is held up.
    socg_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_wr),
        .cfg_mode  (pwdata[socg_pkg::MODE_W-1:0]),
        .mode      (mode),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .seek_step (seek_step),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .q_op      (q_op)
    );

    socg_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_op (q_op),
        .pop     (q_pop),
        .head_op (head_op),
        .stat    (q_stat)
    );

    // The back end carries its own copy of the scan kind in each queued
    // operation, so it never looks at the mode register.
    socg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_op   (head_op),
        .q_stat    (q_stat),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .x_coord   (x_coord),
        .y_coord   (y_coord)
    );

    // A queued radial step must lie within the radial period.
    `SOCG_ASSERT_IMPLIES(a_radial_step_in_range, q_push && (q_op.kind == socg_pkg::SCAN_RADIAL), q_op.step < socg_pkg::STEP_W'(socg_pkg::SPOKE_PERIOD))
    // The queue is never written while full, nor drained while empty.
    `SOCG_ASSERT_NEVER(a_no_push_when_full, q_push && q_stat.full)
    `SOCG_ASSERT_NEVER(a_no_pop_when_empty, q_pop && q_stat.empty)
    // A seek item never reaches the queue.
    `SOCG_ASSERT_IMPLIES(a_seek_not_queued, in_valid && !in_stall && (cmd == socg_pkg::CMD_SEEK), !q_push)

endmodule
